>>> rtl/gf2_poly_ext_gcd_defines.svh
// Assertion macros shared by the extended GCD block.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef GF2_POLY_EXT_GCD_DEFINES_SVH
`define GF2_POLY_EXT_GCD_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define GPEG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define GPEG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gpeg_pkg.sv
// Shared types and constants for the GF(2) polynomial extended GCD block.
// Depends on nothing.
package gpeg_pkg;

  // Width of every payload field on the ports.
  localparam int unsigned FIELD_W = 64;

  typedef struct packed {
    logic [FIELD_W-1:0] poly_a;
    logic [FIELD_W-1:0] poly_b;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] gcd_poly;
    logic [FIELD_W-1:0] coeff_a;
    logic [FIELD_W-1:0] coeff_b;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

>>> rtl/gf2_poly_ext_gcd.sv
// Top level of the GF(2) polynomial extended GCD block: sequencer and row registers.
// Depends on gpeg_pkg, gpeg_shift_xor and gf2_poly_ext_gcd_defines.svh.
//
// Usage: drive in_data and raise start while busy is low; that edge accepts the
// transaction and busy rises in the next cycle. The block returns g = gcd(a, b)
// with Bezout multipliers s and t such that g = s*a + t*b over GF(2)[x]. Input
// bits at or above POLY_WIDTH are ignored, and terms of s and t at x^POLY_WIDTH
// or higher are dropped.
// The result appears on out_data for exactly one cycle, marked by out_valid, in
// the first cycle with busy low again; the receiver cannot stall it, so it must
// be taken then. A new transaction may be started while that result is shown.
// Each step of the sequencer either walks the unsettled degree pointers of the
// two rows down by one bit, does one swap or one shift-and-XOR reduction through
// the shared unit, or issues the result. Only one transaction is worked on at a
// time; start is taken only while busy is low.
// Reset clears the sequencer and the result strobe; nothing else is kept.
`include "gf2_poly_ext_gcd_defines.svh"

module gf2_poly_ext_gcd #(
  parameter int unsigned POLY_WIDTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  gpeg_pkg::in_t  in_data,
  output logic          out_valid,
  output gpeg_pkg::out_t out_data
);

  import gpeg_pkg::*;

  localparam int unsigned DEG_W = (POLY_WIDTH > 1) ? $clog2(POLY_WIDTH) : 1;
  localparam logic [DEG_W-1:0] DEG_TOP = DEG_W'(POLY_WIDTH - 1);

  // Sequencer and working rows.
  state_t                state_r, state_nxt;
  logic [POLY_WIDTH-1:0] r0_r, r0_nxt, s0_r, s0_nxt, t0_r, t0_nxt;
  logic [POLY_WIDTH-1:0] r1_r, r1_nxt, s1_r, s1_nxt, t1_r, t1_nxt;
  logic [DEG_W-1:0]      d0_r, d0_nxt, d1_r, d1_nxt;
  logic                  z0_r, z0_nxt, z1_r, z1_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;

  logic                  norm0, norm1;
  logic [DEG_W-1:0]      shift_k;
  logic [POLY_WIDTH-1:0] r_red, s_red, t_red;

  // A row is normalised once its pointer sits on its top set bit, or it is known zero.
  assign norm0   = z0_r | r0_r[d0_r];
  assign norm1   = z1_r | r1_r[d1_r];
  assign shift_k = d1_r - d0_r;

  // Shared shift-and-XOR unit.
  gpeg_shift_xor #(
    .POLY_WIDTH (POLY_WIDTH),
    .DEG_W      (DEG_W)
  ) u_shift_xor (
    .r0      (r0_r),
    .s0      (s0_r),
    .t0      (t0_r),
    .r1      (r1_r),
    .s1      (s1_r),
    .t1      (t1_r),
    .shift_k (shift_k),
    .r_red   (r_red),
    .s_red   (s_red),
    .t_red   (t_red)
  );

  // State register and control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working rows and the result register carry no reset.
  always_ff @(posedge clk) begin
    r0_r       <= r0_nxt;
    s0_r       <= s0_nxt;
    t0_r       <= t0_nxt;
    r1_r       <= r1_nxt;
    s1_r       <= s1_nxt;
    t1_r       <= t1_nxt;
    d0_r       <= d0_nxt;
    d1_r       <= d1_nxt;
    z0_r       <= z0_nxt;
    z1_r       <= z1_nxt;
    out_data_r <= out_data_nxt;
  end

  // Next state: load, normalise, reduce or swap, and finish.
  always_comb begin
    state_nxt     = state_r;
    r0_nxt        = r0_r;
    s0_nxt        = s0_r;
    t0_nxt        = t0_r;
    r1_nxt        = r1_r;
    s1_nxt        = s1_r;
    t1_nxt        = t1_r;
    d0_nxt        = d0_r;
    d1_nxt        = d1_r;
    z0_nxt        = z0_r;
    z1_nxt        = z1_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          r0_nxt    = in_data.poly_a[POLY_WIDTH-1:0];
          s0_nxt    = POLY_WIDTH'(1);
          t0_nxt    = '0;
          r1_nxt    = in_data.poly_b[POLY_WIDTH-1:0];
          s1_nxt    = '0;
          t1_nxt    = POLY_WIDTH'(1);
          d0_nxt    = DEG_TOP;
          d1_nxt    = DEG_TOP;
          z0_nxt    = 1'b0;
          z1_nxt    = 1'b0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!norm0 || !norm1) begin
          // Walk each unsettled degree pointer down one bit.
          if (!norm0) begin
            if (d0_r == '0) z0_nxt = 1'b1;
            else            d0_nxt = d0_r - DEG_W'(1);
          end
          if (!norm1) begin
            if (d1_r == '0) z1_nxt = 1'b1;
            else            d1_nxt = d1_r - DEG_W'(1);
          end
        end else if (z0_r) begin
          out_data_nxt.gcd_poly = FIELD_W'(r1_r);
          out_data_nxt.coeff_a  = FIELD_W'(s1_r);
          out_data_nxt.coeff_b  = FIELD_W'(t1_r);
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end else if (z1_r) begin
          out_data_nxt.gcd_poly = FIELD_W'(r0_r);
          out_data_nxt.coeff_a  = FIELD_W'(s0_r);
          out_data_nxt.coeff_b  = FIELD_W'(t0_r);
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end else if (d0_r > d1_r) begin
          // Plain swap of the two rows.
          r0_nxt = r1_r;
          s0_nxt = s1_r;
          t0_nxt = t1_r;
          d0_nxt = d1_r;
          r1_nxt = r0_r;
          s1_nxt = s0_r;
          t1_nxt = t0_r;
          d1_nxt = d0_r;
        end else begin
          // Reduce row 1 by row 0, then swap. The reduced row loses its top bit.
          r0_nxt = r_red;
          s0_nxt = s_red;
          t0_nxt = t_red;
          d0_nxt = d1_r;
          r1_nxt = r0_r;
          s1_nxt = s0_r;
          t1_nxt = t0_r;
          d1_nxt = d0_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r == ST_RUN);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencer.
  `GPEG_ASSERT_NEXT(a_start_busy, start && !busy, busy, "Accepted transaction did not raise busy")
  `GPEG_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid, "Result strobe lasted beyond one cycle")
  `GPEG_ASSERT_NOW(a_done_idle, out_valid, !busy, "Result shown while still busy")
  `GPEG_ASSERT_NOW(a_deg_range, busy, (d0_r <= DEG_TOP) && (d1_r <= DEG_TOP), "Degree out of range")
  `GPEG_ASSERT_NEXT(a_finish, busy && norm0 && norm1 && (z0_r || z1_r), out_valid && !busy,
                    "Zero row did not end the transaction")

endmodule

>>> rtl/gpeg_shift_xor.sv
// Shared reduction unit: row 1 XORed with row 0 shifted up by k, for r, s and t.
// Depends on nothing but its parameters; used by the top level sequencer.
module gpeg_shift_xor #(
  parameter int unsigned POLY_WIDTH = 64,
  parameter int unsigned DEG_W      = 6
) (
  input  logic [POLY_WIDTH-1:0] r0,
  input  logic [POLY_WIDTH-1:0] s0,
  input  logic [POLY_WIDTH-1:0] t0,
  input  logic [POLY_WIDTH-1:0] r1,
  input  logic [POLY_WIDTH-1:0] s1,
  input  logic [POLY_WIDTH-1:0] t1,
  input  logic [DEG_W-1:0]      shift_k,
  output logic [POLY_WIDTH-1:0] r_red,
  output logic [POLY_WIDTH-1:0] s_red,
  output logic [POLY_WIDTH-1:0] t_red
);

  // Terms pushed past the top coefficient are dropped by the shift itself.
  assign r_red = r1 ^ (r0 << shift_k);
  assign s_red = s1 ^ (s0 << shift_k);
  assign t_red = t1 ^ (t0 << shift_k);

endmodule
